FILE: rtl/core/joint_path_cost_selector_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the joint path cost selector core
// Checks compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef JOINT_PATH_COST_SELECTOR_CORE_MACROS_SVH
`define JOINT_PATH_COST_SELECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define JPCS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jpcs: implication check failed");

// next-cycle implication
`define JPCS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jpcs: next-cycle check failed");

`else

`define JPCS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define JPCS_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/jpcs_pkg.sv
// ----------------------------------------------------------------------------
// jpcs_pkg
// Shared types and constants of the joint path cost selector.
// ----------------------------------------------------------------------------
package jpcs_pkg;

  localparam int MAX_JOINTS      = 7;
  localparam int JOINTS_DEF      = 7;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int POS_W   = 16;
  localparam int TOL_W   = 15;
  localparam int COST_W  = 32;
  // sum of up to seven 16x16 squares
  localparam int SUMSQ_W = 35;
  localparam int ROOT_W  = 18;

  localparam logic [TOL_W-1:0]  TOL_RESET = 15'd41;
  localparam logic [COST_W-1:0] COST_MAX  = '1;

  // input beat kinds
  typedef enum logic [1:0] {
    KIND_GOAL  = 2'd0,
    KIND_POINT = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // queued operations
  typedef enum logic [1:0] {
    OP_GOAL  = 2'd0,
    OP_POINT = 2'd1,
    OP_EMPTY = 2'd2
  } op_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] joint_0;
    logic signed [15:0] joint_1;
    logic signed [15:0] joint_2;
    logic signed [15:0] joint_3;
    logic signed [15:0] joint_4;
    logic signed [15:0] joint_5;
    logic signed [15:0] joint_6;
    logic               last_point;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] path_cost;
    logic        reaches_goal;
    logic        accepted;
  } out_beat_t;

  typedef struct packed {
    op_e                              op;
    logic                             last;
    logic [MAX_JOINTS-1:0][POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_status_t;

endpackage

FILE: rtl/core/joint_path_cost_selector_core.sv
// ----------------------------------------------------------------------------
// joint_path_cost_selector_core: shortest goal-reaching joint path selector
// A later point squares one difference per joint and takes the root in 18
// steps; a result beat waits while the output stalls.
// The back takes the next queued command only once it is back in idle.
// Async active-low reset: best cost all ones, no goal, no path, tolerance 41.
// ----------------------------------------------------------------------------
`include "joint_path_cost_selector_core_macros.svh"

module joint_path_cost_selector_core #(
  parameter int JOINTS      = jpcs_pkg::JOINTS_DEF,
  parameter int QUEUE_DEPTH = jpcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [jpcs_pkg::TOL_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  jpcs_pkg::in_beat_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output jpcs_pkg::out_beat_t        out_data_o
);
  import jpcs_pkg::*;

  cmd_t         head;
  q_status_t    q_status;
  back_status_t back_status;

  // front: accept and classify beats
  jpcs_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .back_status_i (back_status),
    .head_o        (head),
    .q_status_o    (q_status)
  );

  // back: execute commands
  jpcs_back #(
    .JOINTS (JOINTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .q_status_i  (q_status),
    .status_o    (back_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // checks
  `JPCS_ASSERT_IMP(a_acc_needs_goal, clk_i, rst_ni, out_valid_o && out_data_o.accepted, out_data_o.reaches_goal)
  `JPCS_ASSERT_IMP(a_pop_not_empty, clk_i, rst_ni, back_status.pop, !q_status.empty)
  `JPCS_ASSERT_NXT(a_pop_frees_slot, clk_i, rst_ni, back_status.pop, !q_status.full)
  `JPCS_ASSERT_IMP(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(back_status.busy))

endmodule

FILE: rtl/core/jpcs_queue.sv
// ----------------------------------------------------------------------------
// jpcs_queue
// Small register queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module jpcs_queue #(
  parameter int DEPTH = jpcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jpcs_pkg::cmd_t     push_data_i,
  input  logic               pop_i,
  output jpcs_pkg::cmd_t     head_o,
  output jpcs_pkg::q_status_t status_o
);
  import jpcs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t           mem_q [DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  // pointer wrap and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign head_o          = mem_q[rd_q];
  assign status_o.empty  = (cnt_q == '0);
  assign status_o.full   = (cnt_q == CW'(DEPTH));

endmodule

FILE: rtl/core/jpcs_front.sv
// ----------------------------------------------------------------------------
// jpcs_front
// Accepts input beats, classifies them by kind and queues the commands.
// ----------------------------------------------------------------------------
module jpcs_front #(
  parameter int QUEUE_DEPTH = jpcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  jpcs_pkg::in_beat_t     in_data_i,
  input  jpcs_pkg::back_status_t back_status_i,
  output jpcs_pkg::cmd_t         head_o,
  output jpcs_pkg::q_status_t    q_status_o
);
  import jpcs_pkg::*;

  cmd_t cmd;
  logic keep;
  logic push;

  // classify: unused kind is taken and dropped
  always_comb begin
    cmd.last   = in_data_i.last_point;
    cmd.pos[0] = in_data_i.joint_0;
    cmd.pos[1] = in_data_i.joint_1;
    cmd.pos[2] = in_data_i.joint_2;
    cmd.pos[3] = in_data_i.joint_3;
    cmd.pos[4] = in_data_i.joint_4;
    cmd.pos[5] = in_data_i.joint_5;
    cmd.pos[6] = in_data_i.joint_6;
    unique case (in_data_i.kind)
      KIND_GOAL: begin
        cmd.op = OP_GOAL;
        keep   = 1'b1;
      end
      KIND_POINT: begin
        cmd.op = OP_POINT;
        keep   = 1'b1;
      end
      KIND_EMPTY: begin
        cmd.op = OP_EMPTY;
        keep   = 1'b1;
      end
      default: begin
        cmd.op = OP_POINT;
        keep   = 1'b0;
      end
    endcase
  end

  assign in_stall_o = q_status_o.full;
  assign push       = in_valid_i && !q_status_o.full && keep;

  jpcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd),
    .pop_i       (back_status_i.pop),
    .head_o      (head_o),
    .status_o    (q_status_o)
  );

endmodule

FILE: rtl/core/jpcs_back.sv
// ----------------------------------------------------------------------------
// jpcs_back
// Executes queued commands: segment length by per-joint squares and a
// bitwise square root, cost accumulation, goal check and best-cost update.
// ----------------------------------------------------------------------------
module jpcs_back #(
  parameter int JOINTS = jpcs_pkg::JOINTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jpcs_pkg::TOL_W-1:0]    cfg_wdata_i,
  input  jpcs_pkg::cmd_t                head_i,
  input  jpcs_pkg::q_status_t           q_status_i,
  output jpcs_pkg::back_status_t        status_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output jpcs_pkg::out_beat_t           out_data_o
);
  import jpcs_pkg::*;

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int RW = SUMSQ_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SQ,
    S_SUM,
    S_ROOT,
    S_END,
    S_RES
  } state_e;

  state_e             state_q;
  logic [TOL_W-1:0]   tol_q;
  logic [POS_W-1:0]   goal_q [JOINTS];
  logic               goal_valid_q;
  logic [COST_W-1:0]  best_q;
  logic [COST_W-1:0]  run_q;
  logic               have_prev_q;
  logic               out_valid_q;
  out_beat_t          out_q;

  // datapath registers
  cmd_t               cmd_q;
  logic [POS_W-1:0]   prev_q [JOINTS];
  logic [JW-1:0]      j_q;
  logic [2*POS_W-1:0] sq_q;
  logic               sq_v_q;
  logic [SUMSQ_W-1:0] sum_q;
  logic [SUMSQ_W-1:0] rem_q;
  logic [RW-1:0]      res_q;
  logic [SUMSQ_W-1:0] bit_q;

  logic               out_free;
  logic               emit;
  logic               pop;
  logic [POS_W:0]     dj;
  logic [POS_W:0]     magj;
  logic [RW-1:0]      trial;
  logic               take;
  logic [COST_W:0]    total;
  logic               reaches;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop      = (state_q == S_IDLE) && !q_status_i.empty;
  // a new result beat is loaded this cycle
  assign emit     = out_free &&
                    ((state_q == S_RES) || ((state_q == S_EXEC) && (cmd_q.op == OP_EMPTY)));

  // one joint difference per cycle
  always_comb begin
    dj   = {cmd_q.pos[j_q][POS_W-1], cmd_q.pos[j_q]} - {prev_q[j_q][POS_W-1], prev_q[j_q]};
    magj = dj[POS_W] ? (~dj + 1'b1) : dj;
  end

  // square root step and saturating cost add
  always_comb begin
    trial = res_q + {1'b0, bit_q};
    take  = ({1'b0, rem_q} >= trial);
    total = {1'b0, run_q} + (COST_W + 1)'(res_q[ROOT_W-1:0]);
  end

  // goal check across all joints
  always_comb begin
    logic [POS_W:0] gd;
    logic [POS_W:0] gm;
    reaches = goal_valid_q;
    for (int i = 0; i < JOINTS; i++) begin
      gd = {cmd_q.pos[i][POS_W-1], cmd_q.pos[i]} - {goal_q[i][POS_W-1], goal_q[i]};
      gm = gd[POS_W] ? (~gd + 1'b1) : gd;
      if (gm > {2'b00, tol_q}) begin
        reaches = 1'b0;
      end
    end
  end

  // sequencer, path state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tol_q        <= TOL_RESET;
      for (int i = 0; i < JOINTS; i++) begin
        goal_q[i] <= '0;
      end
      goal_valid_q <= 1'b0;
      best_q       <= COST_MAX;
      run_q        <= '0;
      have_prev_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd_q.op)
            OP_GOAL: begin
              for (int i = 0; i < JOINTS; i++) begin
                goal_q[i] <= cmd_q.pos[i];
              end
              goal_valid_q <= 1'b1;
              best_q       <= COST_MAX;
              run_q        <= '0;
              have_prev_q  <= 1'b0;
              state_q      <= S_IDLE;
            end
            OP_EMPTY: begin
              if (out_free) begin
                out_q       <= '0;
                out_valid_q <= 1'b1;
                best_q      <= COST_MAX;
                run_q       <= '0;
                have_prev_q <= 1'b0;
                state_q     <= S_IDLE;
              end
            end
            OP_POINT: begin
              state_q <= have_prev_q ? S_SQ : S_END;
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_SQ: begin
          if (j_q == JW'(JOINTS - 1)) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (bit_q[0]) begin
            state_q <= S_END;
          end
        end
        S_END: begin
          run_q       <= total[COST_W] ? COST_MAX : total[COST_W-1:0];
          have_prev_q <= 1'b1;
          state_q     <= cmd_q.last ? S_RES : S_IDLE;
        end
        S_RES: begin
          if (out_free) begin
            out_q.path_cost    <= run_q;
            out_q.reaches_goal <= reaches;
            out_q.accepted     <= reaches && (run_q < best_q);
            out_valid_q        <= 1'b1;
            if (reaches && (run_q < best_q)) begin
              best_q <= run_q;
            end
            run_q       <= '0;
            have_prev_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // segment length datapath
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= head_i;
    end
    unique case (state_q)
      S_EXEC: begin
        j_q    <= '0;
        sum_q  <= '0;
        sq_v_q <= 1'b0;
        res_q  <= '0;
      end
      S_SQ: begin
        sq_q   <= magj[POS_W-1:0] * magj[POS_W-1:0];
        sq_v_q <= 1'b1;
        sum_q  <= sum_q + (sq_v_q ? SUMSQ_W'(sq_q) : '0);
        j_q    <= j_q + 1'b1;
      end
      S_SUM: begin
        rem_q <= sum_q + SUMSQ_W'(sq_q);
        res_q <= '0;
        bit_q <= {1'b1, {(SUMSQ_W-1){1'b0}}};
      end
      S_ROOT: begin
        if (take) begin
          rem_q <= rem_q - trial[SUMSQ_W-1:0];
          res_q <= (res_q >> 1) + {1'b0, bit_q};
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_END: begin
        for (int i = 0; i < JOINTS; i++) begin
          prev_q[i] <= cmd_q.pos[i];
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.pop  = pop;
  assign status_o.busy = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_q;

endmodule
